>>> design/dsmp_pkg.sv
package dsmp_pkg;

	// Default configuration
	localparam int ADDRESS_BITS_DEF     = 16;
	localparam int READ_UNIT_BYTES_DEF  = 8;
	localparam int WRITE_UNIT_BYTES_DEF = 8;
	localparam int TASK_QUEUE_DEPTH_DEF = 8;

	// Fixed field widths
	localparam int WORD_W      = 64;
	localparam int WORD_BYTES  = 8;
	localparam int FIELD_W     = 16;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 72;

	// Error codes reported with each result
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_RANGE      = 3'd1,
		ERR_NOT_READY  = 3'd2,
		ERR_READ_FULL  = 3'd3,
		ERR_WRITE_FULL = 3'd4
	} err_code_t;

	// One host task: start byte and byte count
	typedef struct packed {
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] addr;
	} task_t;

	// Task queue control, one set per accepted request
	typedef struct packed {
		logic  pop;
		logic  push;
		task_t push_task;
	} tq_ctrl_t;

	// Task queue status
	typedef struct packed {
		logic  not_empty;
		logic  more;
		logic  full;
		task_t head;
	} tq_stat_t;

endpackage

>>> design/dsmp_ram.sv
module dsmp_ram #(
	parameter int              DATA_WIDTH = 8,
	parameter longint unsigned DEPTH      = 256,
	localparam int             AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/dsmp_task_queue.sv
module dsmp_task_queue import dsmp_pkg::*; #(
	parameter int DEPTH = TASK_QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  tq_ctrl_t ctrl,
	output tq_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          fwd_q;
	task_t         fwd_task_q;
	task_t         ram_rdata;

	logic [PW-1:0] head_inc;
	logic [PW-1:0] head_next;
	logic [SW-1:0] tail_sum;
	logic [PW-1:0] slot;
	logic          full;
	logic          push_ok;
	logic [CW-1:0] count_next;

	// Pointer arithmetic, wrap at the queue depth
	always_comb begin
		head_inc   = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		head_next  = ctrl.pop ? head_inc : head_q;
		tail_sum   = SW'(head_q) + SW'(count_q);
		slot       = PW'((tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum);
		full       = (count_q == CW'(DEPTH));
		push_ok    = ctrl.push && (!full || ctrl.pop);
		count_next = count_q - CW'(ctrl.pop) + CW'(push_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			fwd_q   <= 1'b0;
		end else if (en) begin
			head_q  <= head_next;
			count_q <= count_next;
			fwd_q   <= push_ok && (slot == head_next);
		end
	end

	// Bypass for a push that lands on the next head slot
	always_ff @(posedge clk) begin
		if (en) begin
			fwd_task_q <= ctrl.push_task;
		end
	end

	dsmp_ram #(
		.DATA_WIDTH ($bits(task_t)),
		.DEPTH      (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (en && push_ok),
		.waddr (slot),
		.wdata (ctrl.push_task),
		.re    (en),
		.raddr (head_next),
		.rdata (ram_rdata)
	);

	// Status
	always_comb begin
		stat.not_empty = (count_q != '0);
		stat.more      = (count_q > CW'(1));
		stat.full      = full;
		stat.head      = fwd_q ? fwd_task_q : ram_rdata;
	end

endmodule

>>> design/dsmp_lane_store.sv
module dsmp_lane_store import dsmp_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int LANES        = WORD_BYTES
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ADDRESS_BITS-1:0]      rd_addr,
	input  logic                         wr_go,
	input  logic [ADDRESS_BITS-1:0]      wr_addr,
	input  logic [$clog2(LANES+1)-1:0]   wr_count,
	input  logic [WORD_W-1:0]            wr_word,
	output logic [LANES-1:0][7:0]        rd_lanes
);

	localparam int LB  = $clog2(LANES);
	localparam int LW  = (LANES > 1) ? LB : 1;
	localparam int RW  = ADDRESS_BITS - LB;
	localparam int LCW = $clog2(LANES + 1);

	logic [RW-1:0]              rd_row;
	logic [LW-1:0]              rd_ofs;
	logic [RW-1:0]              wr_row;
	logic [LW-1:0]              wr_ofs;
	logic [WORD_BYTES-1:0][7:0] word_bytes;

	// Byte address split into row and starting lane
	always_comb begin
		rd_row     = RW'(rd_addr >> LB);
		rd_ofs     = LW'(rd_addr % LANES);
		wr_row     = RW'(wr_addr >> LB);
		wr_ofs     = LW'(wr_addr % LANES);
		word_bytes = wr_word;
	end

	// One byte-wide bank per lane; an unaligned chunk touches each bank once
	for (genvar b = 0; b < LANES; b++) begin : g_lane
		logic [RW-1:0] rrow;
		logic [RW-1:0] wrow;
		logic [LW:0]   wdiff;
		logic [LW-1:0] widx;
		logic          wen;
		logic [7:0]    wbyte;

		always_comb begin
			rrow  = rd_row + RW'(rd_ofs > LW'(b));
			wrow  = wr_row + RW'(wr_ofs > LW'(b));
			wdiff = (LW+1)'(LANES + b) - (LW+1)'(wr_ofs);
			widx  = LW'(wdiff % LANES);
			wen   = en && wr_go && (LCW'(widx) < wr_count);
			wbyte = word_bytes[3'(widx)];
		end

		dsmp_ram #(
			.DATA_WIDTH (8),
			.DEPTH      (64'(1) << RW)
		) u_bank (
			.clk   (clk),
			.we    (wen),
			.waddr (wrow),
			.wdata (wbyte),
			.re    (en),
			.raddr (rrow),
			.rdata (rd_lanes[b])
		);
	end

endmodule

>>> design/dma_stream_memory_port.sv
// Streaming memory port: one request per cycle, results in request order.
// A taken request is registered in s1 (bank read), then in the output
// register, which drives m_tvalid and holds while m_tready is held low.
// Throughput: one request per cycle while m_tready does not stall s1.
// Reset clears the task queues, current tasks and stream flags at once; the
// byte memory is not cleared and holds undefined data until written.
module dma_stream_memory_port import dsmp_pkg::*; #(
	parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF,
	parameter int READ_UNIT_BYTES  = READ_UNIT_BYTES_DEF,
	parameter int WRITE_UNIT_BYTES = WRITE_UNIT_BYTES_DEF,
	parameter int TASK_QUEUE_DEPTH = TASK_QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// read_dequeue, write_enqueue, write_word[64], host_read_request,
	// host_read_address[16], host_read_length[16], host_write_request,
	// host_write_address[16], host_write_length[16], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_word[64], read_valid, write_ready, error_code[3], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int UNIT_MAX = (READ_UNIT_BYTES > WRITE_UNIT_BYTES) ?
		READ_UNIT_BYTES : WRITE_UNIT_BYTES;
	localparam int LANES = 1 << $clog2(UNIT_MAX);
	localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int LCW   = $clog2(LANES + 1);
	localparam int NRW   = $clog2(READ_UNIT_BYTES + 1);
	localparam int NWW   = $clog2(WRITE_UNIT_BYTES + 1);
	localparam int AB    = ADDRESS_BITS;

	// Request fields
	logic               in_dequeue;
	logic               in_enqueue;
	logic [WORD_W-1:0]  in_word;
	logic               in_rd_req;
	logic [FIELD_W-1:0] in_rd_addr;
	logic [FIELD_W-1:0] in_rd_len;
	logic               in_wr_req;
	logic [FIELD_W-1:0] in_wr_addr;
	logic [FIELD_W-1:0] in_wr_len;

	assign in_dequeue = s_tdata[0];
	assign in_enqueue = s_tdata[1];
	assign in_word    = s_tdata[65:2];
	assign in_rd_req  = s_tdata[66];
	assign in_rd_addr = s_tdata[82:67];
	assign in_rd_len  = s_tdata[98:83];
	assign in_wr_req  = s_tdata[99];
	assign in_wr_addr = s_tdata[115:100];
	assign in_wr_len  = s_tdata[131:116];

	// Task state
	logic [AB-1:0]      rd_addr_q;
	logic [FIELD_W-1:0] rd_rem_q;
	logic [AB-1:0]      wr_addr_q;
	logic [FIELD_W-1:0] wr_rem_q;
	logic               rvalid_q;
	logic               wready_q;

	// Pipeline
	logic                       s1_valid;
	logic                       s1_fetch;
	logic                       s1_rvalid;
	logic                       s1_wready;
	err_code_t                  s1_err;
	logic [LW-1:0]              s1_ofs;
	logic [NRW-1:0]             s1_count;
	logic                       m_valid_q;
	logic [WORD_W-1:0]          out_word_q;
	logic                       out_rvalid_q;
	logic                       out_wready_q;
	err_code_t                  out_err_q;
	logic [WORD_W-1:0]          last_word_q;

	logic                       accept;
	logic                       s1_adv;
	tq_ctrl_t                   rq_ctrl;
	tq_ctrl_t                   wq_ctrl;
	tq_stat_t                   rq_stat;
	tq_stat_t                   wq_stat;
	logic [LANES-1:0][7:0]      rd_lanes;

	logic                       do_read;
	logic                       rpop;
	logic                       rok;
	logic [AB-1:0]              eff_raddr;
	logic [FIELD_W-1:0]         eff_rrem;
	logic [NRW-1:0]             rd_n;
	logic                       fetch;
	logic [AB-1:0]              rd_addr_next;
	logic [FIELD_W-1:0]         rd_rem_next;
	logic                       rvalid_next;
	logic                       we_ok;
	logic                       wpop;
	logic                       wok;
	logic [AB-1:0]              eff_waddr;
	logic [FIELD_W-1:0]         eff_wrem;
	logic [NWW-1:0]             wr_n;
	logic                       wr_go;
	logic [AB-1:0]              wr_addr_next;
	logic [FIELD_W-1:0]         wr_rem_next;
	logic                       wready_next;
	logic                       rq_fail;
	logic                       wq_fail;
	err_code_t                  err;
	logic [WORD_BYTES-1:0][7:0] fetch_bytes;
	logic [WORD_W-1:0]          word_s1;

	// Task fits within the byte memory
	function automatic logic in_range(task_t t);
		logic [32:0] sum;
		sum = 33'(t.addr) + 33'(t.len);
		return sum <= (33'(1) << ADDRESS_BITS);
	endfunction

	// Handshake: s1 always moves on when the output register frees up
	assign s1_adv   = !m_valid_q || m_tready;
	assign s_tready = !s1_valid || s1_adv;
	assign accept   = s_tvalid && s_tready;

	// Read step, write step, then queue pushes
	always_comb begin
		do_read   = in_dequeue || !rvalid_q;
		rpop      = do_read && (rd_rem_q == '0) && rq_stat.not_empty;
		rok       = in_range(rq_stat.head);
		eff_raddr = rd_addr_q;
		eff_rrem  = rd_rem_q;
		if (rpop) begin
			eff_raddr = rok ? AB'(rq_stat.head.addr) : '0;
			eff_rrem  = rok ? rq_stat.head.len : '0;
		end
		rd_n  = (eff_rrem < FIELD_W'(READ_UNIT_BYTES)) ? NRW'(eff_rrem) :
			NRW'(READ_UNIT_BYTES);
		fetch = do_read && (eff_rrem != '0);

		rd_addr_next = rd_addr_q;
		rd_rem_next  = rd_rem_q;
		rvalid_next  = rvalid_q;
		if (do_read) begin
			rvalid_next  = fetch;
			rd_addr_next = fetch ? eff_raddr + AB'(rd_n) : eff_raddr;
			rd_rem_next  = fetch ? eff_rrem - FIELD_W'(rd_n) : eff_rrem;
		end

		we_ok     = in_enqueue && wready_q;
		wpop      = we_ok && (wr_rem_q == '0) && wq_stat.not_empty;
		wok       = in_range(wq_stat.head);
		eff_waddr = wr_addr_q;
		eff_wrem  = wr_rem_q;
		if (wpop) begin
			eff_waddr = wok ? AB'(wq_stat.head.addr) : '0;
			eff_wrem  = wok ? wq_stat.head.len : '0;
		end
		wr_n  = (eff_wrem < FIELD_W'(WRITE_UNIT_BYTES)) ? NWW'(eff_wrem) :
			NWW'(WRITE_UNIT_BYTES);
		wr_go = we_ok && (eff_wrem != '0);

		wr_addr_next = wr_addr_q;
		wr_rem_next  = wr_rem_q;
		if (we_ok) begin
			wr_addr_next = wr_go ? eff_waddr + AB'(wr_n) : eff_waddr;
			wr_rem_next  = wr_go ? eff_wrem - FIELD_W'(wr_n) : eff_wrem;
		end
		wready_next = (wr_rem_next != '0) || (wpop ? wq_stat.more : wq_stat.not_empty);

		rq_fail = in_rd_req && rq_stat.full && !rpop;
		wq_fail = in_wr_req && wq_stat.full && !wpop;

		// First error in step order wins
		if (rpop && !rok) begin
			err = ERR_RANGE;
		end else if (wpop && !wok) begin
			err = ERR_RANGE;
		end else if (in_enqueue && !wready_q) begin
			err = ERR_NOT_READY;
		end else if (rq_fail) begin
			err = ERR_READ_FULL;
		end else if (wq_fail) begin
			err = ERR_WRITE_FULL;
		end else begin
			err = ERR_NONE;
		end
	end

	// Queue requests
	always_comb begin
		rq_ctrl.pop            = rpop;
		rq_ctrl.push           = in_rd_req;
		rq_ctrl.push_task.addr = in_rd_addr;
		rq_ctrl.push_task.len  = in_rd_len;
		wq_ctrl.pop            = wpop;
		wq_ctrl.push           = in_wr_req;
		wq_ctrl.push_task.addr = in_wr_addr;
		wq_ctrl.push_task.len  = in_wr_len;
	end

	dsmp_task_queue #(
		.DEPTH (TASK_QUEUE_DEPTH)
	) u_read_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.ctrl   (rq_ctrl),
		.stat   (rq_stat)
	);

	dsmp_task_queue #(
		.DEPTH (TASK_QUEUE_DEPTH)
	) u_write_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.ctrl   (wq_ctrl),
		.stat   (wq_stat)
	);

	dsmp_lane_store #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.LANES        (LANES)
	) u_lane_store (
		.clk      (clk),
		.en       (accept),
		.rd_addr  (eff_raddr),
		.wr_go    (wr_go),
		.wr_addr  (eff_waddr),
		.wr_count (LCW'(wr_n)),
		.wr_word  (in_word),
		.rd_lanes (rd_lanes)
	);

	// Task state and s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_rem_q  <= '0;
			wr_addr_q <= '0;
			wr_rem_q  <= '0;
			rvalid_q  <= 1'b0;
			wready_q  <= 1'b0;
			s1_valid  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rd_addr_q <= rd_addr_next;
				rd_rem_q  <= rd_rem_next;
				wr_addr_q <= wr_addr_next;
				wr_rem_q  <= wr_rem_next;
				rvalid_q  <= rvalid_next;
				wready_q  <= wready_next;
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= s1_valid;
			end
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_fetch  <= fetch;
			s1_rvalid <= rvalid_next;
			s1_wready <= wready_next;
			s1_err    <= err;
			s1_ofs    <= LW'(eff_raddr % LANES);
			s1_count  <= rd_n;
		end
	end

	// Rotate bank data into chunk order, zero beyond the chunk length
	for (genvar i = 0; i < WORD_BYTES; i++) begin : g_byte
		if (i < READ_UNIT_BYTES) begin : g_used
			logic [LW:0]   lsum;
			logic [LW-1:0] lane;
			always_comb begin
				lsum           = (LW+1)'(s1_ofs) + (LW+1)'(i);
				lane           = LW'(lsum % LANES);
				fetch_bytes[i] = (NRW'(i) < s1_count) ? rd_lanes[lane] : 8'h00;
			end
		end else begin : g_unused
			assign fetch_bytes[i] = 8'h00;
		end
	end

	assign word_s1 = s1_fetch ? fetch_bytes : (s1_rvalid ? last_word_q : '0);

	// Output register
	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_word_q   <= word_s1;
			out_rvalid_q <= s1_rvalid;
			out_wready_q <= s1_wready;
			out_err_q    <= s1_err;
			last_word_q  <= word_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, out_err_q, out_wready_q, out_rvalid_q, out_word_q};

endmodule

>>> design/dsmp_checker.sv
module dsmp_checker import dsmp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// Every taken request shows a result once through the s1 and output registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("request taken but no result two cycles later");

	// No read data shown without read_valid
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[64]) |-> (m_tdata[63:0] == '0))
		else $error("read word not zero while read_valid low");

	// Error code stays within the defined codes, pad stays zero
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[68:66] <= 3'd4) && (m_tdata[71:69] == 3'b000)))
		else $error("bad error code or pad bits");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind dma_stream_memory_port dsmp_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
